[hw/rtl/bam_pkg.sv]
// Shared types, constants and operation codes for the byte-array ALU.
`default_nettype none

package bam_pkg;

    // Operand width in bytes and the widths that follow from it.
    localparam int WIDTH_BYTES = 4;
    localparam int OP_W        = WIDTH_BYTES * 8;
    localparam int EXT_W       = OP_W + 8;
    localparam int ITER_W      = (OP_W > 1) ? $clog2(OP_W) : 1;

    // Fixed widths of the transaction fields.
    localparam int OPC_W   = 4;
    localparam int OPND_W  = 32;
    localparam int SHCNT_W = 6;
    localparam int RES_W   = 40;

    // Operation codes.
    typedef enum logic [OPC_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_SHL = 4'd3,
        OP_SHR = 4'd4,
        OP_EQ  = 4'd5,
        OP_LT  = 4'd6,
        OP_LE  = 4'd7,
        OP_GT  = 4'd8,
        OP_GE  = 4'd9
    } op_t;

    // Input transaction.
    typedef struct packed {
        logic [OPC_W-1:0]   operation;
        logic [OPND_W-1:0]  operand_a;
        logic [OPND_W-1:0]  operand_b;
        logic [SHCNT_W-1:0] shift_count;
    } in_item_t;

    // Output transaction.
    typedef struct packed {
        logic [RES_W-1:0] result_value;
        logic             compare_true;
    } out_item_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_mul;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bam_dp.sv]
// Datapath of the byte-array ALU: operand registers, Booth step unit and result register.
`default_nettype none

module bam_dp (
    input  wire logic               clk,
    input  wire bam_pkg::in_item_t  in_data,
    input  wire bam_pkg::dp_cmd_t   cmd,
    output bam_pkg::dp_stat_t       stat,
    output bam_pkg::out_item_t      out_data
);
    import bam_pkg::*;

    logic [OPC_W-1:0]   op_reg;
    logic [OP_W-1:0]    a_reg;
    logic [OP_W-1:0]    b_reg;
    logic [SHCNT_W-1:0] cnt_reg;
    logic [OP_W-1:0]    acc_reg;
    logic               prev_reg;
    out_item_t          out_reg;

    logic [OP_W-1:0]    acc_next;
    logic [OP_W-1:0]    shl_val;
    logic [OP_W-1:0]    shr_val;
    logic               shift_over;
    logic [EXT_W-1:0]   val;
    logic               cmp;
    out_item_t          res;

    // The controller needs to know whether the offered transaction is a multiply.
    assign stat.in_is_mul = (in_data.operation == OP_MUL);

    // One radix-2 Booth step: the pair (current bit, previous bit) picks add or subtract.
    always_comb
    begin
        acc_next = acc_reg;
        if (!b_reg[0] && prev_reg)
        begin
            acc_next = acc_reg + a_reg;
        end
        else if (b_reg[0] && !prev_reg)
        begin
            acc_next = acc_reg - a_reg;
        end
    end

    // Shifts give zero once the count reaches the operand width.
    assign shift_over = ({1'b0, cnt_reg} >= (SHCNT_W + 1)'(OP_W));
    assign shl_val    = shift_over ? '0 : (a_reg << cnt_reg);
    assign shr_val    = shift_over ? '0 : (a_reg >> cnt_reg);

    // Result selection for the finished transaction.
    always_comb
    begin
        val = '0;
        cmp = 1'b0;
        case (op_reg)
            OP_ADD: val = {8'b0, a_reg} + {8'b0, b_reg};
            OP_SUB: val = {8'b0, a_reg} - {8'b0, b_reg};
            OP_MUL: val = EXT_W'(acc_reg);
            OP_SHL: val = EXT_W'(shl_val);
            OP_SHR: val = EXT_W'(shr_val);
            OP_EQ:  cmp = (a_reg == b_reg);
            OP_LT:  cmp = (a_reg <  b_reg);
            OP_LE:  cmp = (a_reg <= b_reg);
            OP_GT:  cmp = (a_reg >  b_reg);
            OP_GE:  cmp = (a_reg >= b_reg);
            default:
            begin
                val = '0;
                cmp = 1'b0;
            end
        endcase
        res.result_value = RES_W'(val);
        res.compare_true = cmp;
    end

    // Operand capture, Booth iteration and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_data.operation;
            a_reg    <= OP_W'(in_data.operand_a);
            b_reg    <= OP_W'(in_data.operand_b);
            cnt_reg  <= in_data.shift_count;
            acc_reg  <= '0;
            prev_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            acc_reg  <= acc_next;
            prev_reg <= b_reg[0];
            a_reg    <= a_reg << 1;
            b_reg    <= b_reg >> 1;
        end
        if (cmd.finish)
        begin
            out_reg <= res;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

[hw/rtl/bam_ctrl.sv]
// Controller of the byte-array ALU: transaction sequencing, Booth iteration count and output valid.
`default_nettype none

module bam_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire bam_pkg::dp_stat_t stat,
    output bam_pkg::dp_cmd_t       cmd
);
    import bam_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // State register, iteration counter and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    state_next = stat.in_is_mul ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL:
            begin
                cmd.step  = 1'b1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(OP_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Move the result out once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register holds a transaction until the consumer takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[hw/rtl/byte_array_alu_booth_multiply_core.sv]
// Top level of the byte-array ALU with a radix-2 Booth multiplier.
`default_nettype none

// Integer ALU over operands of WIDTH_BYTES bytes: add, subtract (one byte wider result,
// two's complement for subtract), multiply (low operand-width bits of the product),
// logical shifts (zero at or beyond the width) and unsigned compares. Every input
// transaction gives exactly one output transaction. One transaction is worked at a time:
// add, subtract, shifts and compares are registered straight from the loaded operands;
// multiply first runs one Booth add-and-shift step per operand bit in the accumulator.
// A new input is accepted as soon as the previous result has moved into the output
// register, even while that result still waits for the consumer.
module byte_array_alu_booth_multiply_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bam_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bam_pkg::out_item_t      out_data
);
    import bam_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing.
    bam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and result register.
    bam_dp u_dp (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

[dv/tb_byte_array_alu_booth_multiply_core.sv]
// Self-checking testbench for the byte-array ALU with the Booth multiplier.
`timescale 1ns / 100ps

module tb_byte_array_alu_booth_multiply_core;
    import bam_pkg::*;

    // Operation codes that the block leaves unused; they must give an all-zero result.
    localparam logic [OPC_W-1:0] OPC_RSVD_FIRST = 4'd10;
    localparam logic [OPC_W-1:0] OPC_RSVD_LAST  = 4'd15;

    localparam int MAX_IDLE       = 18;
    localparam int RANDOM_OPS     = 700;
    localparam int TAIL_CYCLES    = OP_W + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // One pending operation with the idle gap before it and an optional drain request.
    typedef struct {
        in_item_t    item;
        int unsigned gap;
        bit          drain;
    } alu_op_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    alu_op_t     pending_ops[$];
    out_item_t   expected_results[$];
    int unsigned gap_count;
    int unsigned stall_left;
    int unsigned stall_draw;
    int unsigned results_seen;
    int unsigned quiet_cycles;
    int unsigned fail_count;

    byte_array_alu_booth_multiply_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Computes the result that one operation must produce.
    function automatic out_item_t alu_result(in_item_t it);
        logic [OP_W-1:0]    a;
        logic [OP_W-1:0]    b;
        logic [OP_W-1:0]    prod;
        logic [EXT_W-1:0]   wide;
        logic [SHCNT_W-1:0] cnt;
        out_item_t          r;
        a    = it.operand_a[OP_W-1:0];
        b    = it.operand_b[OP_W-1:0];
        cnt  = it.shift_count;
        wide = '0;
        r    = '0;
        case (it.operation)
            OP_ADD: wide = EXT_W'(a) + EXT_W'(b);
            OP_SUB: wide = EXT_W'(a) - EXT_W'(b);
            OP_MUL:
            begin
                // The low half of the product does not depend on signedness.
                prod = a * b;
                wide = EXT_W'(prod);
            end
            OP_SHL: wide = (cnt >= OP_W) ? '0 : EXT_W'(OP_W'(a << cnt));
            OP_SHR: wide = (cnt >= OP_W) ? '0 : EXT_W'(a >> cnt);
            OP_EQ:  r.compare_true = (a == b);
            OP_LT:  r.compare_true = (a < b);
            OP_LE:  r.compare_true = (a <= b);
            OP_GT:  r.compare_true = (a > b);
            OP_GE:  r.compare_true = (a >= b);
            default: ;
        endcase
        r.result_value = RES_W'(wide);
        return r;
    endfunction

    // Draws an operand, weighted toward the corner values.
    function automatic logic [OPND_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return OPND_W'(1);
            3: return OPND_W'(1) << (OP_W - 1);
            4: return OPND_W'($urandom_range(0, 255));
            default: return OPND_W'($urandom);
        endcase
    endfunction

    task automatic queue_op(logic [OPC_W-1:0] op, logic [OPND_W-1:0] a,
                            logic [OPND_W-1:0] b, logic [SHCNT_W-1:0] cnt,
                            int unsigned gap, bit drain);
        alu_op_t e;
        e.item.operation   = op;
        e.item.operand_a   = a;
        e.item.operand_b   = b;
        e.item.shift_count = cnt;
        e.gap              = gap;
        e.drain            = drain;
        pending_ops.push_back(e);
    endtask

    // Driver: presents queued operations after their idle gap and records expectations.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            gap_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(alu_result(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_ops[0].drain && expected_results.size() != 0)
                    in_valid <= 1'b0;
                else if (gap_count < pending_ops[0].gap)
                begin
                    in_valid  <= 1'b0;
                    gap_count <= gap_count + 1;
                end
                else
                begin
                    in_valid  <= 1'b1;
                    in_data   <= pending_ops[0].item;
                    gap_count <= 0;
                    void'(pending_ops.pop_front());
                end
            end
        end
    end

    // Monitor: checks each result transaction and stalls the output side at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            stall_left   <= 0;
            results_seen <= 0;
            fail_count   <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: result_value=%h compare_true=%b",
                       out_data.result_value, out_data.compare_true);
                fail_count <= fail_count + 1;
            end
            else
            begin
                if (out_data.result_value !== expected_results[0].result_value)
                begin
                    $error("result_value: expected %h, actual %h",
                           expected_results[0].result_value, out_data.result_value);
                end
                if (out_data.compare_true !== expected_results[0].compare_true)
                begin
                    $error("compare_true: expected %b, actual %b",
                           expected_results[0].compare_true, out_data.compare_true);
                end
                if ((out_data.result_value !== expected_results[0].result_value) ||
                    (out_data.compare_true !== expected_results[0].compare_true))
                begin
                    fail_count <= fail_count + 1;
                end
                void'(expected_results.pop_front());
            end
            results_seen <= results_seen + 1;
            // Every third stretch of results is taken without stalls.
            stall_draw = ((results_seen / 120) % 3 == 1) ? 0 : $urandom_range(0, MAX_IDLE);
            stall_left <= stall_draw;
            out_ready  <= (stall_draw == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog on cycles in which neither side moves a transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[byte_array_alu_booth_multiply_core] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [OPC_W-1:0]  op;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        int unsigned       gap;
        quiet_cycles = 0;

        // Directed corners: carries, borrows, multiply extremes, shift limits,
        // equality on every compare but less-than, and the unused codes.
        queue_op(OP_ADD, '1, '1, '0, 0, 1'b0);
        queue_op(OP_ADD, '0, '0, '0, 0, 1'b0);
        queue_op(OP_SUB, '0, OPND_W'(1), '0, 0, 1'b0);
        queue_op(OP_SUB, '1, '0, '0, 0, 1'b0);
        queue_op(OP_MUL, '1, '1, '0, 0, 1'b0);
        queue_op(OP_MUL, OPND_W'(1) << (OP_W - 1), OPND_W'(2), '0, 0, 1'b0);
        queue_op(OP_MUL, 32'hAAAA_AAAA, 32'h5555_5555, '0, 0, 1'b0);
        queue_op(OP_MUL, 32'h1234_5678, '0, '0, 0, 1'b0);
        queue_op(OP_SHL, '1, '1, SHCNT_W'(0), 0, 1'b0);
        queue_op(OP_SHL, '1, '0, SHCNT_W'(OP_W - 1), 0, 1'b0);
        queue_op(OP_SHL, '1, '0, SHCNT_W'(OP_W), 0, 1'b0);
        queue_op(OP_SHL, '1, '0, '1, 0, 1'b0);
        queue_op(OP_SHR, '1, '0, SHCNT_W'(1), 0, 1'b0);
        queue_op(OP_SHR, '1, '1, SHCNT_W'(OP_W), 0, 1'b0);
        queue_op(OP_SHR, '1, '0, SHCNT_W'(40), 0, 1'b0);
        queue_op(OP_EQ, 32'hDEAD_BEEF, 32'hDEAD_BEEF, '0, 0, 1'b0);
        queue_op(OP_LT, '0, '1, '0, 0, 1'b0);
        queue_op(OP_LE, '1, '1, '0, 0, 1'b0);
        queue_op(OP_GT, '1, '1, '0, 0, 1'b0);
        queue_op(OP_GT, '1, '0, '0, 0, 1'b0);
        queue_op(OP_GE, '0, '0, '0, 0, 1'b0);
        queue_op(OPC_RSVD_FIRST, '1, '1, '1, 0, 1'b0);
        queue_op(OPC_RSVD_LAST, '1, OPND_W'(5), SHCNT_W'(3), 0, 1'b0);

        // Random operations; every other block of a hundred runs without input gaps,
        // and now and then the input side drains all results before going on.
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    op = OPC_RSVD_FIRST +
                         OPC_W'($urandom_range(0, OPC_RSVD_LAST - OPC_RSVD_FIRST));
                end
                1, 2, 3, 4, 5: op = OP_MUL;
                default: op = OPC_W'($urandom_range(OP_ADD, OP_GE));
            endcase
            a = pick_operand();
            b = ($urandom_range(0, 3) == 0) ? a : pick_operand();
            gap = ((i / 100) % 2 == 1) ? 0 : $urandom_range(0, MAX_IDLE);
            queue_op(op, a, b,
                     ($urandom_range(0, 4) == 0) ? SHCNT_W'($urandom_range(0, 63))
                                                 : SHCNT_W'($urandom_range(0, OP_W)),
                     gap, (i % 150 == 149) || (i == 0));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("[byte_array_alu_booth_multiply_core] OK");
        else
            $display("[byte_array_alu_booth_multiply_core] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/bam_pkg.sv
hw/rtl/bam_dp.sv
hw/rtl/bam_ctrl.sv
hw/rtl/byte_array_alu_booth_multiply_core.sv
dv/tb_byte_array_alu_booth_multiply_core.sv
